// ----- hdl/assert_macros.svh -----
// Assertion macros used by the top level of the matrix inverse block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Checked property, disabled while rst is high.
`define MIG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked property, also checked during reset.
`define MIG_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MIG_ASSERT(lbl, prop, msg)
`define MIG_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ----- hdl/mig_pkg.sv -----
// Types, constants and codes shared by the matrix inverse block.
package mig_pkg;

  localparam int MAX_DIM_DEF   = 8;
  localparam int FRAC_BITS_DEF = 16;

  localparam logic signed [31:0] SAT_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] SAT_MIN = 32'sh8000_0000;

  // Register index of the dimension register.
  localparam logic REG_DIMENSION = 1'b0;

  typedef enum logic [1:0] {
    CELL_KEEP,
    CELL_LOAD,
    CELL_MULSUB
  } cell_op_t;

  typedef struct packed {
    cell_op_t           op;
    logic signed [31:0] data;
    logic               capture;
  } cell_cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_INIT,
    ST_CAPT,
    ST_SEARCH,
    ST_SWAP,
    ST_DIV_RD,
    ST_DIV_RUN,
    ST_DIV_WR,
    ST_ELIM_CAPT,
    ST_ELIM,
    ST_EMIT
  } state_t;

endpackage

// ----- hdl/mig_cell.sv -----
// One row cell: a rotating ring of work and result words with multiply-subtract.
module mig_cell #(
  parameter int MAX_DIM   = mig_pkg::MAX_DIM_DEF,
  parameter int FRAC_BITS = mig_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  mig_pkg::cell_cmd_t cmd,
  input  logic signed [31:0] pivot_word,
  output logic signed [31:0] tap,
  output logic signed [31:0] factor,
  output logic               clip
);

  localparam int RING = 2 * MAX_DIM;
  localparam logic signed [64:0] LIM_HI = 65'sh0_7FFF_FFFF;
  localparam logic signed [64:0] LIM_LO = -65'sh0_8000_0000;

  logic signed [31:0] ring [RING-1];
  logic signed [31:0] p1_word;
  logic signed [63:0] p1_prod;
  logic               p1_sub;

  logic signed [63:0] prod_sh;
  logic signed [63:0] prod_t;
  logic               round_up;
  logic signed [64:0] diff;
  logic signed [31:0] new_word;

  assign tap = ring[0];

  // Truncate the product toward zero, then subtract and clip.
  always_comb begin
    prod_sh  = p1_prod >>> FRAC_BITS;
    round_up = p1_prod[63] && (p1_prod[FRAC_BITS-1:0] != '0);
    prod_t   = prod_sh + {63'b0, round_up};
    diff     = {p1_word[31], p1_word[31], p1_word[31], p1_word[31], p1_word[31],
                p1_word[31], p1_word[31], p1_word[31], p1_word[31], p1_word[31],
                p1_word[31], p1_word[31], p1_word[31], p1_word[31], p1_word[31],
                p1_word[31], p1_word[31], p1_word[31], p1_word[31], p1_word[31],
                p1_word[31], p1_word[31], p1_word[31], p1_word[31], p1_word[31],
                p1_word[31], p1_word[31], p1_word[31], p1_word[31], p1_word[31],
                p1_word[31], p1_word[31], p1_word[31], p1_word}
               - {prod_t[63], prod_t};
    clip     = 1'b0;
    new_word = p1_word;
    if (p1_sub) begin
      if (diff > LIM_HI) begin
        new_word = mig_pkg::SAT_MAX;
        clip     = 1'b1;
      end else if (diff < LIM_LO) begin
        new_word = mig_pkg::SAT_MIN;
        clip     = 1'b1;
      end else begin
        new_word = diff[31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_sub <= 1'b0;
    end else begin
      p1_sub <= (cmd.op == mig_pkg::CELL_MULSUB);
    end
    p1_word <= (cmd.op == mig_pkg::CELL_LOAD) ? cmd.data : ring[0];
    p1_prod <= pivot_word * factor;
    if (cmd.capture) begin
      factor <= ring[0];
    end
    for (int i = 0; i < RING - 2; i++) begin
      ring[i] <= ring[i+1];
    end
    ring[RING-2] <= new_word;
  end

endmodule

// ----- hdl/mig_div.sv -----
// Bit-serial signed fixed-point divider with saturation.
module mig_div #(
  parameter int FRAC_BITS = mig_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [31:0] num,
  input  logic signed [31:0] den,
  output logic               done,
  output logic signed [31:0] quotient,
  output logic               clip
);

  localparam int W   = 32 + FRAC_BITS;
  localparam int CNT_W = $clog2(W + 1);

  logic [W-1:0]     dvd;
  logic [W-1:0]     quo;
  logic [31:0]      rem;
  logic [31:0]      den_mag;
  logic [CNT_W-1:0] cnt;
  logic             running;
  logic             neg;

  logic [32:0]      trial;
  logic             qbit;
  logic [31:0]      num_mag;
  logic [W-32:0]    quo_hi;

  assign num_mag = num[31] ? 32'(-num) : 32'(num);
  assign trial   = {rem, dvd[W-1]};
  assign qbit    = trial >= {1'b0, den_mag};
  assign quo_hi  = quo[W-1:31];

  always_comb begin
    clip     = 1'b0;
    quotient = neg ? -$signed(quo[31:0]) : $signed(quo[31:0]);
    if (!neg && quo_hi != '0) begin
      clip     = 1'b1;
      quotient = mig_pkg::SAT_MAX;
    end else if (neg && quo_hi != '0 && !(quo_hi == (W-31)'(1) && quo[30:0] == '0)) begin
      clip     = 1'b1;
      quotient = mig_pkg::SAT_MIN;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= CNT_W'(W);
      end else if (running) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
    if (start) begin
      dvd     <= {num_mag, {FRAC_BITS{1'b0}}};
      den_mag <= den[31] ? 32'(-den) : 32'(den);
      neg     <= num[31] ^ den[31];
      rem     <= '0;
      quo     <= '0;
    end else if (running) begin
      rem <= qbit ? 32'(trial - {1'b0, den_mag}) : trial[31:0];
      dvd <= {dvd[W-2:0], 1'b0};
      quo <= {quo[W-2:0], qbit};
    end
  end

endmodule

// ----- hdl/matrix_inverse_gauss_jordan.sv -----
// Top level: Gauss-Jordan matrix inverse over a chain of rotating row cells.
// Load: one element per beat; each waits for its column to reach the ring tap.
// Inversion: one identity pass, then per column ring passes, a pivot search over rows col to
// n-1 and 2n divisions, one for each used work or result word of the diagonal row.
// Emission: n*n result beats, each when its result column reaches the tap; the receiver cannot stall.
// Reset: control clears at once, dimension reads 1; the matrix stores need no clearing pass.
`include "assert_macros.svh"
module matrix_inverse_gauss_jordan #(
  parameter int MAX_DIM   = mig_pkg::MAX_DIM_DEF,
  parameter int FRAC_BITS = mig_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  // command channel
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] element_value,
  // result channel
  output logic               result_valid,
  output logic signed [31:0] inverse_value,
  output logic               last_element,
  output logic               singular,
  output logic               saturated,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int RING  = 2 * MAX_DIM;
  localparam int ROT_W = $clog2(RING);
  localparam int ROW_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int N_W   = $clog2(MAX_DIM + 1);
  localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;
  localparam logic [ROT_W-1:0] ROT_LAST = ROT_W'(RING - 1);

  mig_pkg::state_t state, state_next;

  // Control registers
  logic [3:0]       dimension;
  logic [ROT_W-1:0] rot;        // column at every cell's tap this cycle
  logic [ROT_W-1:0] pass_cnt;
  logic [ROT_W-1:0] kpos;
  logic [ROW_W-1:0] load_row, load_col;
  logic [ROW_W-1:0] col, scan, piv;
  logic [ROW_W-1:0] out_row, out_col;
  logic [32:0]      best_mag;
  logic signed [31:0] pivot_val;
  logic signed [31:0] hold_value;
  logic             sing_flag;
  logic             clip_seen;

  // Cell chain wiring
  mig_pkg::cell_cmd_t cmd [MAX_DIM];
  logic signed [31:0] tap [MAX_DIM];
  logic signed [31:0] fac [MAX_DIM];
  logic               cclip [MAX_DIM];
  logic signed [31:0] pivot_word;
  logic               cell_clip_any;

  // Divider
  logic               div_start, div_done, div_clip;
  logic signed [31:0] div_q;

  // Derived
  logic [N_W-1:0]   n_eff;
  logic [ROW_W-1:0] n_m1;
  logic             cfg_wr;
  logic             accept;
  logic             pass_end;
  logic             kpos_ok;
  logic             emit_fire;
  logic             emit_last;
  logic [32:0]      cand_mag;
  logic             better;
  logic [ROW_W-1:0] piv_sel;
  logic signed [31:0] piv_val_sel;

  function automatic logic [32:0] mag33(input logic signed [31:0] x);
    logic signed [32:0] w;
    w = {x[31], x};
    return w[32] ? 33'(-w) : 33'(w);
  endfunction

  // True for columns that belong to the active n-by-n work or result halves.
  function automatic logic pos_used(input logic [ROT_W-1:0] k, input logic [N_W-1:0] n);
    int kk;
    kk = int'(k);
    return (kk < int'(n)) || (kk >= MAX_DIM && kk - MAX_DIM < int'(n));
  endfunction

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == mig_pkg::REG_DIMENSION) ? {28'b0, dimension} : 32'b0;

  // Clamp the register into 1..MAX_DIM
  always_comb begin
    if (dimension == 4'd0) begin
      n_eff = N_W'(1);
    end else if (int'(dimension) > MAX_DIM) begin
      n_eff = N_W'(MAX_DIM);
    end else begin
      n_eff = N_W'(dimension);
    end
  end
  assign n_m1 = ROW_W'(n_eff - 1'b1);

  assign busy     = (state != mig_pkg::ST_IDLE);
  assign accept   = start && !busy;
  assign pass_end = (pass_cnt == ROT_LAST);
  assign kpos_ok  = pos_used(kpos, n_eff);

  // Pivot search compares one row per cycle
  assign cand_mag    = mag33(fac[scan]);
  assign better      = (scan == col) || (cand_mag > best_mag);
  assign piv_sel     = better ? scan : piv;
  assign piv_val_sel = fac[piv_sel];

  assign emit_fire = (state == mig_pkg::ST_EMIT) &&
                     (rot == ROT_W'(MAX_DIM + int'(out_col)));
  assign emit_last = (out_row == n_m1) && (out_col == n_m1);

  always_comb begin
    cell_clip_any = 1'b0;
    for (int i = 0; i < MAX_DIM; i++) begin
      cell_clip_any = cell_clip_any | cclip[i];
    end
  end

  generate
    for (genvar g = 0; g < MAX_DIM; g++) begin : g_cell
      mig_cell #(
        .MAX_DIM  (MAX_DIM),
        .FRAC_BITS(FRAC_BITS)
      ) u_cell (
        .clk       (clk),
        .rst       (rst),
        .cmd       (cmd[g]),
        .pivot_word(pivot_word),
        .tap       (tap[g]),
        .factor    (fac[g]),
        .clip      (cclip[g])
      );
    end
  endgenerate

  mig_div #(
    .FRAC_BITS(FRAC_BITS)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .num     (tap[col]),
    .den     (pivot_val),
    .done    (div_done),
    .quotient(div_q),
    .clip    (div_clip)
  );

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      mig_pkg::ST_IDLE: begin
        if (accept) state_next = mig_pkg::ST_LOAD;
      end
      mig_pkg::ST_LOAD: begin
        if (rot == ROT_W'(load_col)) begin
          if (load_row == n_m1 && load_col == n_m1) state_next = mig_pkg::ST_INIT;
          else state_next = mig_pkg::ST_IDLE;
        end
      end
      mig_pkg::ST_INIT: begin
        if (pass_end) state_next = mig_pkg::ST_CAPT;
      end
      mig_pkg::ST_CAPT: begin
        if (rot == ROT_W'(col)) state_next = mig_pkg::ST_SEARCH;
      end
      mig_pkg::ST_SEARCH: begin
        if (scan == n_m1) begin
          if (piv_val_sel == 32'sd0) state_next = mig_pkg::ST_EMIT;
          else if (piv_sel != col) state_next = mig_pkg::ST_SWAP;
          else state_next = mig_pkg::ST_DIV_RD;
        end
      end
      mig_pkg::ST_SWAP: begin
        if (pass_end) state_next = mig_pkg::ST_DIV_RD;
      end
      mig_pkg::ST_DIV_RD: begin
        if (!kpos_ok) begin
          if (kpos == ROT_LAST) state_next = mig_pkg::ST_ELIM_CAPT;
        end else if (rot == kpos) begin
          state_next = mig_pkg::ST_DIV_RUN;
        end
      end
      mig_pkg::ST_DIV_RUN: begin
        if (div_done) state_next = mig_pkg::ST_DIV_WR;
      end
      mig_pkg::ST_DIV_WR: begin
        if (rot == kpos) begin
          state_next = (kpos == ROT_LAST) ? mig_pkg::ST_ELIM_CAPT : mig_pkg::ST_DIV_RD;
        end
      end
      mig_pkg::ST_ELIM_CAPT: begin
        if (rot == ROT_W'(col)) state_next = mig_pkg::ST_ELIM;
      end
      mig_pkg::ST_ELIM: begin
        if (pass_end) state_next = (col == n_m1) ? mig_pkg::ST_EMIT : mig_pkg::ST_CAPT;
      end
      mig_pkg::ST_EMIT: begin
        if (emit_fire && emit_last) state_next = mig_pkg::ST_IDLE;
      end
      default: state_next = mig_pkg::ST_IDLE;
    endcase
  end

  // Cell commands and divider start
  always_comb begin
    for (int i = 0; i < MAX_DIM; i++) begin
      cmd[i] = '{op: mig_pkg::CELL_KEEP, data: 32'sd0, capture: 1'b0};
    end
    pivot_word = tap[col];
    div_start  = 1'b0;
    unique case (state)
      mig_pkg::ST_LOAD: begin
        // drop the held beat into its row when its column reaches the tap
        if (rot == ROT_W'(load_col)) begin
          cmd[load_row].op   = mig_pkg::CELL_LOAD;
          cmd[load_row].data = hold_value;
        end
      end
      mig_pkg::ST_INIT: begin
        // write the identity into the result half of every row
        if (int'(rot) >= MAX_DIM) begin
          for (int i = 0; i < MAX_DIM; i++) begin
            cmd[i].op   = mig_pkg::CELL_LOAD;
            cmd[i].data = (int'(rot) - MAX_DIM == i) ? ONE : 32'sd0;
          end
        end
      end
      mig_pkg::ST_CAPT, mig_pkg::ST_ELIM_CAPT: begin
        if (rot == ROT_W'(col)) begin
          for (int i = 0; i < MAX_DIM; i++) begin
            cmd[i].capture = 1'b1;
          end
        end
      end
      mig_pkg::ST_SWAP: begin
        // exchange the pivot row and the diagonal row word by word
        cmd[col].op   = mig_pkg::CELL_LOAD;
        cmd[col].data = tap[piv];
        cmd[piv].op   = mig_pkg::CELL_LOAD;
        cmd[piv].data = tap[col];
      end
      mig_pkg::ST_DIV_RD: begin
        div_start = kpos_ok && (rot == kpos);
      end
      mig_pkg::ST_DIV_WR: begin
        if (rot == kpos) begin
          cmd[col].op   = mig_pkg::CELL_LOAD;
          cmd[col].data = div_q;
        end
      end
      mig_pkg::ST_ELIM: begin
        // every other active row subtracts its factor times the pivot row
        if (pos_used(rot, n_eff)) begin
          for (int i = 0; i < MAX_DIM; i++) begin
            if (ROW_W'(i) != col && i < int'(n_eff)) cmd[i].op = mig_pkg::CELL_MULSUB;
          end
        end
      end
      mig_pkg::ST_IDLE, mig_pkg::ST_SEARCH, mig_pkg::ST_DIV_RUN, mig_pkg::ST_EMIT: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= mig_pkg::ST_IDLE;
      dimension    <= 4'd1;
      rot          <= '0;
      pass_cnt     <= '0;
      kpos         <= '0;
      load_row     <= '0;
      load_col     <= '0;
      col          <= '0;
      scan         <= '0;
      piv          <= '0;
      out_row      <= '0;
      out_col      <= '0;
      sing_flag    <= 1'b0;
      clip_seen    <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      rot          <= (rot == ROT_LAST) ? '0 : rot + 1'b1;
      result_valid <= emit_fire;

      if (cell_clip_any || (div_done && div_clip)) clip_seen <= 1'b1;

      unique case (state)
        mig_pkg::ST_LOAD: begin
          if (rot == ROT_W'(load_col)) begin
            if (load_col == n_m1) begin
              load_col <= '0;
              load_row <= load_row + 1'b1;
            end else begin
              load_col <= load_col + 1'b1;
            end
            if (load_row == n_m1 && load_col == n_m1) begin
              load_row  <= '0;
              pass_cnt  <= '0;
              sing_flag <= 1'b0;
            end
          end
        end
        mig_pkg::ST_INIT: begin
          pass_cnt <= pass_cnt + 1'b1;
          if (pass_end) col <= '0;
        end
        mig_pkg::ST_CAPT: begin
          scan <= col;
          piv  <= col;
        end
        mig_pkg::ST_SEARCH: begin
          if (better) best_mag <= cand_mag;
          piv  <= piv_sel;
          scan <= scan + 1'b1;
          if (scan == n_m1) begin
            pivot_val <= piv_val_sel;
            pass_cnt  <= '0;
            kpos      <= '0;
            if (piv_val_sel == 32'sd0) begin
              sing_flag <= 1'b1;
              out_row   <= '0;
              out_col   <= '0;
            end
          end
        end
        mig_pkg::ST_SWAP: begin
          pass_cnt <= pass_cnt + 1'b1;
          kpos     <= '0;
        end
        mig_pkg::ST_DIV_RD: begin
          if (!kpos_ok) kpos <= kpos + 1'b1;
        end
        mig_pkg::ST_DIV_WR: begin
          if (rot == kpos) kpos <= kpos + 1'b1;
        end
        mig_pkg::ST_ELIM_CAPT: begin
          pass_cnt <= '0;
        end
        mig_pkg::ST_ELIM: begin
          pass_cnt <= pass_cnt + 1'b1;
          if (pass_end) begin
            if (col == n_m1) begin
              out_row <= '0;
              out_col <= '0;
            end else begin
              col <= col + 1'b1;
            end
          end
        end
        mig_pkg::ST_EMIT: begin
          if (emit_fire) begin
            if (out_col == n_m1) begin
              out_col <= '0;
              out_row <= out_row + 1'b1;
            end else begin
              out_col <= out_col + 1'b1;
            end
            // drop the clip history once the last beat leaves
            if (emit_last) clip_seen <= 1'b0;
          end
        end
        mig_pkg::ST_IDLE, mig_pkg::ST_DIV_RUN: begin
        end
        default: begin
        end
      endcase

      // a dimension write restarts loading
      if (cfg_wr && paddr[2] == mig_pkg::REG_DIMENSION) begin
        dimension <= pwdata[3:0];
        load_row  <= '0;
        load_col  <= '0;
        clip_seen <= 1'b0;
      end
    end

    if (accept) hold_value <= element_value;

    // register the result beat; the values hold until the next beat
    if (emit_fire) begin
      inverse_value <= sing_flag ? 32'sd0 : tap[out_row];
      last_element  <= emit_last;
      singular      <= sing_flag;
      saturated     <= clip_seen | cell_clip_any;
    end
  end

  `MIG_ASSERT(a_result_while_busy, result_valid |-> $past(busy), "result beat without work")
  `MIG_ASSERT(a_accept_busy, (start && !busy) |=> busy, "accepted beat did not raise busy")
  `MIG_ASSERT(a_singular_zero, (result_valid && singular) |-> (inverse_value == 32'sd0),
              "singular beat carries a nonzero value")
  `MIG_ASSERT(a_last_ends, (result_valid && last_element) |=> !result_valid,
              "result beat after the last element")

endmodule
